### sv/hrvs_pkg.sv
// Shared types and constants for the HRV time-domain statistics block.
package hrvs_pkg;

  localparam int MAX_INTERVALS_DEF = 1048576;
  localparam int FRACTION_BITS     = 4;
  localparam int CNT_W             = 20;

  localparam logic [19:0] OUT_MAX    = 20'hFFFFF;
  localparam logic [13:0] PCT_SCALE  = 14'd10000;
  localparam logic [15:0] RESET_THR  = 16'd50;
  localparam logic [23:0] RESET_SEG  = 24'd300000;
  localparam logic [15:0] SEGK_MAX   = 16'hFFFF;

  localparam logic [7:0] CFG_NN50_THR = 8'd0;
  localparam logic [7:0] CFG_SEG_LEN  = 8'd1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FEW_IV    = 2'd1;
  localparam logic [1:0] STATUS_FEW_SEG   = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } math_op_t;

  typedef struct packed {
    logic     start;
    math_op_t op;
  } math_req_t;

  typedef struct packed {
    logic done;
  } math_rsp_t;

endpackage

### sv/hrvs_math.sv
// Bit-serial arithmetic unit: shift-add multiply, restoring divide, digit-by-digit square root.
module hrvs_math (
  input  logic                clk,
  input  logic                rst,
  input  hrvs_pkg::math_req_t req,
  input  logic [127:0]        a,
  input  logic [63:0]         b,
  output hrvs_pkg::math_rsp_t rsp,
  output logic [127:0]        result
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_SQRT} mstate_t;

  mstate_t      state;
  logic         done;
  logic         done_next;
  logic [127:0] mcand;
  logic [63:0]  mplier;
  logic [127:0] acc;
  logic [63:0]  rem;
  logic [63:0]  num_lo;
  logic [63:0]  dvs;
  logic [63:0]  quo;
  logic [63:0]  rad;
  logic [35:0]  srem;
  logic [31:0]  root;
  logic [5:0]   cnt;

  logic [63:0]  div_shift;
  logic         div_ge;
  logic [63:0]  div_diff;
  logic [35:0]  sq_cur;
  logic [35:0]  sq_trial;
  logic         sq_ge;

  always_comb begin
    div_shift = {rem[62:0], num_lo[63]};
    // the bit shifted out of the remainder means it already exceeds the divisor
    div_ge    = rem[63] || (div_shift >= dvs);
    div_diff  = div_shift - dvs;
    sq_cur    = {srem[33:0], rad[63:62]};
    sq_trial  = {2'b00, root, 2'b01};
    sq_ge     = sq_cur >= sq_trial;
  end

  // finish a divide by zero, a saturating divide and an unknown op at once
  always_comb begin
    done_next = 1'b0;
    case (state)
      M_IDLE: begin
        if (req.start) begin
          case (req.op)
            hrvs_pkg::OP_MUL:  done_next = 1'b0;
            hrvs_pkg::OP_SQRT: done_next = 1'b0;
            hrvs_pkg::OP_DIV:  done_next = (b == 64'd0) || (a[127:64] >= b);
            default:           done_next = 1'b1;
          endcase
        end
      end
      M_MUL:   done_next = (mplier == 64'd0);
      M_DIV:   done_next = (cnt == 6'd63);
      M_SQRT:  done_next = (cnt == 6'd31);
      default: done_next = 1'b0;
    endcase
  end

  assign rsp.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            case (req.op)
              hrvs_pkg::OP_MUL: begin
                mcand  <= {64'd0, a[63:0]};
                mplier <= b;
                acc    <= '0;
                state  <= M_MUL;
              end
              hrvs_pkg::OP_DIV: begin
                if (b == 64'd0) begin
                  result <= '0;
                end else if (a[127:64] >= b) begin
                  // quotient does not fit: saturate
                  result <= {64'd0, {64{1'b1}}};
                end else begin
                  rem    <= a[127:64];
                  num_lo <= a[63:0];
                  dvs    <= b;
                  quo    <= '0;
                  cnt    <= '0;
                  state  <= M_DIV;
                end
              end
              hrvs_pkg::OP_SQRT: begin
                rad   <= a[63:0];
                srem  <= '0;
                root  <= '0;
                cnt   <= '0;
                state <= M_SQRT;
              end
              default: begin
                result <= '0;
              end
            endcase
          end
        end
        M_MUL: begin
          if (mplier == 64'd0) begin
            result <= acc;
            state  <= M_IDLE;
          end else begin
            if (mplier[0]) acc <= acc + mcand;
            mcand  <= {mcand[126:0], 1'b0};
            mplier <= {1'b0, mplier[63:1]};
          end
        end
        M_DIV: begin
          rem    <= div_ge ? div_diff : div_shift;
          quo    <= {quo[62:0], div_ge};
          num_lo <= {num_lo[62:0], 1'b0};
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            result <= {64'd0, quo[62:0], div_ge};
            state  <= M_IDLE;
          end
        end
        M_SQRT: begin
          srem <= sq_ge ? (sq_cur - sq_trial) : sq_cur;
          root <= {root[30:0], sq_ge};
          rad  <= {rad[61:0], 2'b00};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            result <= {96'd0, root[30:0], sq_ge};
            state  <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

### sv/hrv_time_domain_stats_core.sv
// Top level: HRV time-domain statistics sequencer around a shared bit-serial math unit.
//
// Usage: R-peak times (ms) enter on the s_ stream; s_tlast marks the last peak of a
// record. Each peak after the first forms an RR interval, saturated to 16 bits, and
// updates the interval, successive-difference, NN50 and segment accumulators.
// After the last peak one result transaction leaves on the m_ stream carrying mean RR,
// SDNN, RMSSD, NN50, pNN50, SDANN, SDANN index and SDSD in m_tdata and the status in
// m_tuser; the record state is then cleared while the registers keep their values.
// Registers are written on the cfg_ channel (index 0 NN50 threshold, 1 segment length);
// the user must write them only while the block is idle, which the block does not enforce.
// cfg_ready is always high. The time per peak is set by the serial multiplier squaring
// the interval and its difference, one multiplier bit per cycle. A closing segment adds
// divides, multiplies and a square root in the shared unit; the final peak adds the
// divides, multiplies and square roots of the final statistics.
// Reset: synchronous rst clears all record state and loads the register defaults
// (threshold 50 ms, segment length 300000 ms).
// Stall: a finished result waits in the output register; further peaks are accepted
// meanwhile, and a following result holds the sequencer until the register frees.
module hrv_time_domain_stats_core #(
  parameter int MAX_INTERVALS = hrvs_pkg::MAX_INTERVALS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] peak_time_ms
  input  logic         s_tlast,   // last_peak
  output logic         m_tvalid,
  input  logic         m_tready,
  // [19:0] mean_rr, [39:20] sdnn, [59:40] rmssd, [79:60] nn50_count, [93:80] pnn50,
  // [113:94] sdann, [133:114] sdann_index, [153:134] sdsd, [159:154] zero
  output logic [159:0] m_tdata,
  output logic [1:0]   m_tuser,   // [1:0] status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam int CAP_INT = (MAX_INTERVALS < (1 << hrvs_pkg::CNT_W)) ?
                           MAX_INTERVALS : (1 << hrvs_pkg::CNT_W);
  localparam logic [hrvs_pkg::CNT_W-1:0] CAP = hrvs_pkg::CNT_W'(CAP_INT - 1);
  localparam int SH2 = 2 * hrvs_pkg::FRACTION_BITS;

  typedef enum logic [5:0] {
    S_IDLE, S_PEAK, S_IVSQ, S_ADSQ, S_SEGCHK, S_SEG_MEAN, S_SEG_MSQ, S_SEG_ACC,
    S_SD_START, S_SD_M1, S_SD_M2, S_SD_M3, S_SD_DV, S_SD_SQ, S_FIN,
    S_F_MEAN, S_F_MEAN_W, S_F_SDNN, S_F_SDNN_R, S_F_RMS, S_F_RMS_D, S_F_RMS_S,
    S_F_PNN, S_F_PNN_M, S_F_PNN_D, S_F_SDANN, S_F_SDANN_R, S_F_IDX, S_F_IDX_D,
    S_F_SDSD, S_F_SDSD_R, S_EMIT
  } state_t;

  state_t state;
  state_t state_d;
  state_t sd_ret;

  logic [15:0] thr;
  logic [23:0] seglen;

  // record state
  logic [31:0]        prev_peak;
  logic               have_prev;
  logic [15:0]        prev_iv;
  logic [19:0]        count;
  logic [35:0]        isum;
  logic [51:0]        isq;
  logic signed [36:0] dsum;
  logic [51:0]        dsq;
  logic [19:0]        over;
  logic [24:0]        ssum;
  logic [40:0]        ssq;
  logic [19:0]        sitems;
  logic [15:0]        segk;
  logic [35:0]        msum;
  logic [55:0]        msq;
  logic [35:0]        stdsum;

  // work registers
  logic [31:0]        peak_in;
  logic               last_in;
  logic [15:0]        iv;
  logic signed [16:0] dv;
  logic [15:0]        adv;
  logic [19:0]        mean;
  logic [39:0]        msqv;
  logic [127:0]       t1;
  logic [19:0]        sd_n;
  logic [63:0]        sd_sum;
  logic [63:0]        sd_sq;
  logic               sd_sh;
  logic [31:0]        sd_res;
  logic [19:0]        r_mean;
  logic [19:0]        r_sdnn;
  logic [19:0]        r_rms;
  logic [13:0]        r_pnn;
  logic [19:0]        r_sdann;
  logic [19:0]        r_idx;
  logic [19:0]        r_sdsd;

  hrvs_pkg::math_req_t mreq;
  hrvs_pkg::math_op_t  mop;
  hrvs_pkg::math_rsp_t mrsp;
  logic [127:0]        ma;
  logic [63:0]         mb;
  logic [127:0]        mres;

  logic [31:0]        raw;
  logic [15:0]        iv_new;
  logic signed [16:0] d_new;
  logic [15:0]        ad_new;
  logic [36:0]        abs_ds;
  logic [19:0]        m_cnt;
  logic [128:0]       sd_diff;

  hrvs_math u_math (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .a      (ma),
    .b      (mb),
    .rsp    (mrsp),
    .result (mres)
  );

  function automatic logic [19:0] sat_out(input logic [127:0] v);
    return (v > 128'(hrvs_pkg::OUT_MAX)) ? hrvs_pkg::OUT_MAX : v[19:0];
  endfunction

  always_comb begin
    raw     = peak_in - prev_peak;
    iv_new  = (raw[31:16] != 16'd0) ? 16'hFFFF : raw[15:0];
    d_new   = $signed({1'b0, iv_new}) - $signed({1'b0, prev_iv});
    ad_new  = d_new[16] ? 16'(-d_new) : 16'(d_new);
    abs_ds  = dsum[36] ? 37'(-dsum) : 37'(dsum);
    m_cnt   = (count == 20'd0) ? 20'd0 : count - 20'd1;
    sd_diff = {1'b0, t1} - {1'b0, mres};
  end

  // start the math unit in the first cycle of every state that waits for it
  always_comb begin
    mreq.start = (state != state_d) &&
                 (state inside {S_IVSQ, S_ADSQ, S_SEG_MEAN, S_SEG_MSQ, S_SD_M1, S_SD_M2,
                                S_SD_M3, S_SD_DV, S_SD_SQ, S_F_MEAN_W, S_F_RMS_D,
                                S_F_RMS_S, S_F_PNN_M, S_F_PNN_D, S_F_IDX_D});
    mreq.op    = mop;
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= hrvs_pkg::RESET_THR;
      seglen <= hrvs_pkg::RESET_SEG;
    end else if (cfg_valid) begin
      case (cfg_index)
        hrvs_pkg::CFG_NN50_THR: thr    <= cfg_data[15:0];
        hrvs_pkg::CFG_SEG_LEN:  seglen <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      state_d    <= S_IDLE;
      sd_ret     <= S_IDLE;
      mop        <= hrvs_pkg::OP_MUL;
      m_tvalid   <= 1'b0;
      prev_peak  <= '0;
      have_prev  <= 1'b0;
      prev_iv    <= '0;
      count      <= '0;
      isum       <= '0;
      isq        <= '0;
      dsum       <= '0;
      dsq        <= '0;
      over       <= '0;
      ssum       <= '0;
      ssq        <= '0;
      sitems     <= '0;
      segk       <= '0;
      msum       <= '0;
      msq        <= '0;
      stdsum     <= '0;
    end else begin
      state_d <= state;
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            peak_in <= s_tdata;
            last_in <= s_tlast;
            state   <= S_PEAK;
          end
        end
        S_PEAK: begin
          prev_peak <= peak_in;
          have_prev <= 1'b1;
          if (have_prev && (count < CAP)) begin
            iv    <= iv_new;
            dv    <= d_new;
            adv   <= ad_new;
            mop   <= hrvs_pkg::OP_MUL;
            ma    <= {112'd0, iv_new};
            mb    <= {48'd0, iv_new};
            state <= S_IVSQ;
          end else begin
            state <= S_FIN;
          end
        end
        S_IVSQ: begin
          if (mrsp.done) begin
            prev_iv <= iv;
            count   <= count + 20'd1;
            isum    <= isum + 36'(iv);
            isq     <= isq + 52'(mres[31:0]);
            ssum    <= ssum + 25'(iv);
            ssq     <= ssq + 41'(mres[31:0]);
            sitems  <= sitems + 20'd1;
            if (count != 20'd0) begin
              mop   <= hrvs_pkg::OP_MUL;
              ma    <= {112'd0, adv};
              mb    <= {48'd0, adv};
              state <= S_ADSQ;
            end else begin
              state <= S_SEGCHK;
            end
          end
        end
        S_ADSQ: begin
          if (mrsp.done) begin
            dsum  <= dsum + 37'(dv);
            dsq   <= dsq + 52'(mres[31:0]);
            if (adv > thr) over <= over + 20'd1;
            state <= S_SEGCHK;
          end
        end
        S_SEGCHK: begin
          if (ssum >= {1'b0, seglen}) begin
            if (segk != hrvs_pkg::SEGK_MAX) begin
              mop   <= hrvs_pkg::OP_DIV;
              ma    <= 128'(ssum) << hrvs_pkg::FRACTION_BITS;
              mb    <= 64'(sitems);
              state <= S_SEG_MEAN;
            end else begin
              // counter full: drop the segment
              ssum   <= '0;
              ssq    <= '0;
              sitems <= '0;
              state  <= S_FIN;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_SEG_MEAN: begin
          if (mrsp.done) begin
            mean  <= mres[19:0];
            mop   <= hrvs_pkg::OP_MUL;
            ma    <= 128'(mres[19:0]);
            mb    <= 64'(mres[19:0]);
            state <= S_SEG_MSQ;
          end
        end
        S_SEG_MSQ: begin
          if (mrsp.done) begin
            msqv   <= mres[39:0];
            sd_n   <= sitems;
            sd_sum <= 64'(ssum);
            sd_sq  <= 64'(ssq);
            sd_sh  <= 1'b1;
            sd_ret <= S_SEG_ACC;
            state  <= S_SD_START;
          end
        end
        S_SEG_ACC: begin
          msum   <= msum + 36'(mean);
          msq    <= msq + 56'(msqv);
          stdsum <= stdsum + 36'(sd_res);
          segk   <= segk + 16'd1;
          ssum   <= '0;
          ssq    <= '0;
          sitems <= '0;
          state  <= S_FIN;
        end
        // sample standard deviation: sqrt((n*sq - sum^2) << sh / (n*(n-1)))
        S_SD_START: begin
          if (sd_n < 20'd2) begin
            sd_res <= '0;
            state  <= sd_ret;
          end else begin
            mop   <= hrvs_pkg::OP_MUL;
            ma    <= {64'd0, sd_sq};
            mb    <= 64'(sd_n);
            state <= S_SD_M1;
          end
        end
        S_SD_M1: begin
          if (mrsp.done) begin
            t1    <= mres;
            mop   <= hrvs_pkg::OP_MUL;
            ma    <= {64'd0, sd_sum};
            mb    <= sd_sum;
            state <= S_SD_M2;
          end
        end
        S_SD_M2: begin
          if (mrsp.done) begin
            if (sd_diff[128]) begin
              sd_res <= '0;
              state  <= sd_ret;
            end else begin
              t1    <= sd_sh ? (sd_diff[127:0] << SH2) : sd_diff[127:0];
              mop   <= hrvs_pkg::OP_MUL;
              ma    <= 128'(sd_n);
              mb    <= 64'(sd_n - 20'd1);
              state <= S_SD_M3;
            end
          end
        end
        S_SD_M3: begin
          if (mrsp.done) begin
            mop   <= hrvs_pkg::OP_DIV;
            ma    <= t1;
            mb    <= mres[63:0];
            state <= S_SD_DV;
          end
        end
        S_SD_DV: begin
          if (mrsp.done) begin
            mop   <= hrvs_pkg::OP_SQRT;
            ma    <= {64'd0, mres[63:0]};
            state <= S_SD_SQ;
          end
        end
        S_SD_SQ: begin
          if (mrsp.done) begin
            sd_res <= mres[31:0];
            state  <= sd_ret;
          end
        end
        S_FIN: begin
          state <= last_in ? S_F_MEAN : S_IDLE;
        end
        S_F_MEAN: begin
          if (count != 20'd0) begin
            mop   <= hrvs_pkg::OP_DIV;
            ma    <= 128'(isum) << hrvs_pkg::FRACTION_BITS;
            mb    <= 64'(count);
            state <= S_F_MEAN_W;
          end else begin
            r_mean <= '0;
            state  <= S_F_SDNN;
          end
        end
        S_F_MEAN_W: begin
          if (mrsp.done) begin
            r_mean <= sat_out(mres);
            state  <= S_F_SDNN;
          end
        end
        S_F_SDNN: begin
          sd_n   <= count;
          sd_sum <= 64'(isum);
          sd_sq  <= 64'(isq);
          sd_sh  <= 1'b1;
          sd_ret <= S_F_SDNN_R;
          state  <= S_SD_START;
        end
        S_F_SDNN_R: begin
          r_sdnn <= sat_out(128'(sd_res));
          state  <= S_F_RMS;
        end
        S_F_RMS: begin
          if (m_cnt != 20'd0) begin
            mop   <= hrvs_pkg::OP_DIV;
            ma    <= 128'(dsq) << SH2;
            mb    <= 64'(m_cnt);
            state <= S_F_RMS_D;
          end else begin
            r_rms <= '0;
            state <= S_F_PNN;
          end
        end
        S_F_RMS_D: begin
          if (mrsp.done) begin
            mop   <= hrvs_pkg::OP_SQRT;
            ma    <= {64'd0, mres[63:0]};
            state <= S_F_RMS_S;
          end
        end
        S_F_RMS_S: begin
          if (mrsp.done) begin
            r_rms <= sat_out(mres);
            state <= S_F_PNN;
          end
        end
        S_F_PNN: begin
          if (m_cnt != 20'd0) begin
            mop   <= hrvs_pkg::OP_MUL;
            ma    <= 128'(hrvs_pkg::PCT_SCALE);
            mb    <= 64'(over);
            state <= S_F_PNN_M;
          end else begin
            r_pnn <= '0;
            state <= S_F_SDANN;
          end
        end
        S_F_PNN_M: begin
          if (mrsp.done) begin
            mop   <= hrvs_pkg::OP_DIV;
            ma    <= mres;
            mb    <= 64'(m_cnt);
            state <= S_F_PNN_D;
          end
        end
        S_F_PNN_D: begin
          if (mrsp.done) begin
            r_pnn <= (mres > 128'(hrvs_pkg::PCT_SCALE)) ? hrvs_pkg::PCT_SCALE : mres[13:0];
            state <= S_F_SDANN;
          end
        end
        S_F_SDANN: begin
          sd_n   <= 20'(segk);
          sd_sum <= 64'(msum);
          sd_sq  <= 64'(msq);
          sd_sh  <= 1'b0;
          sd_ret <= S_F_SDANN_R;
          state  <= S_SD_START;
        end
        S_F_SDANN_R: begin
          r_sdann <= sat_out(128'(sd_res));
          state   <= S_F_IDX;
        end
        S_F_IDX: begin
          if (segk != 16'd0) begin
            mop   <= hrvs_pkg::OP_DIV;
            ma    <= 128'(stdsum);
            mb    <= 64'(segk);
            state <= S_F_IDX_D;
          end else begin
            r_idx <= '0;
            state <= S_F_SDSD;
          end
        end
        S_F_IDX_D: begin
          if (mrsp.done) begin
            r_idx <= sat_out(mres);
            state <= S_F_SDSD;
          end
        end
        S_F_SDSD: begin
          sd_n   <= m_cnt;
          sd_sum <= 64'(abs_ds);
          sd_sq  <= 64'(dsq);
          sd_sh  <= 1'b1;
          sd_ret <= S_F_SDSD_R;
          state  <= S_SD_START;
        end
        S_F_SDSD_R: begin
          r_sdsd <= sat_out(128'(sd_res));
          state  <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, r_sdsd, r_idx, r_sdann, r_pnn, over, r_rms, r_sdnn, r_mean};
            if (count < 20'd3) begin
              m_tuser <= hrvs_pkg::STATUS_FEW_IV;
            end else if (segk < 16'd2) begin
              m_tuser <= hrvs_pkg::STATUS_FEW_SEG;
            end else begin
              m_tuser <= hrvs_pkg::STATUS_OK;
            end
            prev_peak <= '0;
            have_prev <= 1'b0;
            prev_iv   <= '0;
            count     <= '0;
            isum      <= '0;
            isq       <= '0;
            dsum      <= '0;
            dsq       <= '0;
            over      <= '0;
            ssum      <= '0;
            ssq       <= '0;
            sitems    <= '0;
            segk      <= '0;
            msum      <= '0;
            msq       <= '0;
            stdsum    <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction is in work");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("interval count beyond capacity");

  a_pnn_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[93:80] <= hrvs_pkg::PCT_SCALE))
    else $error("pnn50 out of range");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == hrvs_pkg::STATUS_OK || m_tuser == hrvs_pkg::STATUS_FEW_IV ||
                  m_tuser == hrvs_pkg::STATUS_FEW_SEG))
    else $error("invalid status code");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!m_tvalid || m_tready)) |=> (count == 20'd0 && !have_prev))
    else $error("record state not cleared after result");

endmodule
